### hw/rtl/mls_pkg.sv
// Package for the multidrop link supervisor: register map, action and command codes,
// controller/datapath command and status structs. No dependencies.
package mls_pkg;

   localparam int MaxUnits   = 8;
   localparam int WireScale  = 10000;
   localparam int MaxResults = 16;

   localparam logic [2:0] ADDR_LINK_READY  = 3'd0;
   localparam logic [2:0] ADDR_ACTIVE      = 3'd1;
   localparam logic [2:0] ADDR_KEEPALIVE   = 3'd2;
   localparam logic [2:0] ADDR_REPROBE     = 3'd3;
   localparam logic [2:0] ADDR_DROP        = 3'd4;

   localparam logic [2:0] ACT_TICK    = 3'd0;
   localparam logic [2:0] ACT_OUTCOME = 3'd1;
   localparam logic [2:0] ACT_SETPOS  = 3'd2;
   localparam logic [2:0] ACT_SETVEL  = 3'd3;
   localparam logic [2:0] ACT_HALT    = 3'd4;
   localparam logic [2:0] ACT_ESTOP   = 3'd5;

   localparam logic [3:0] CMD_KEEPALIVE  = 4'd1;
   localparam logic [3:0] CMD_PROBE      = 4'd2;
   localparam logic [3:0] CMD_READ_POS   = 4'd3;
   localparam logic [3:0] CMD_ENERGIZE   = 4'd7;
   localparam logic [3:0] CMD_EXIT_SAFE  = 4'd8;
   localparam logic [3:0] CMD_SET_POS    = 4'd9;
   localparam logic [3:0] CMD_SET_VEL    = 4'd10;
   localparam logic [3:0] CMD_HALT       = 4'd11;
   localparam logic [3:0] CMD_DEENERGIZE = 4'd12;

   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_PROBE = 2'd1;
   localparam logic [1:0] PEND_READ  = 2'd2;

   typedef struct packed {
      logic       load;        // capture the request
      logic       scan_step;   // look at one unit in the keepalive scan
      logic       poll;        // do the poll part of a tick
      logic       outcome;     // settle the pending request
      logic       energize;    // mark sel unit energized, touch
      logic       touch;       // update last command of sel unit
      logic       deenergize;  // deenergize scan unit
      logic       emit;        // push one result beat
      logic [3:0] kind;
      logic       unit_scan;   // result unit from scan counter
      logic       arg_pos;
      logic       arg_vel;
      logic       last;
      logic       scan_clr;
      logic       scan_inc;
   } ctrl_type;

   typedef struct packed {
      logic [2:0] action;
      logic       link_ready;
      logic       sel_energized;
      logic       scan_done;     // scan counter reached unit limit
      logic       scan_last;     // scan counter is on the last unit
      logic       scan_hit;      // scan unit energized and idle long enough
      logic       no_units;
      logic       poll_emit;     // poll would send something
      logic       poll_connected;
      logic       outcome_energize;
      logic       out_busy;      // result register still full
   } stat_type;

endpackage

### hw/rtl/mls_datapath.sv
// Datapath of the multidrop link supervisor: per-unit state, poll state, result register.
// Depends on mls_pkg.
module mls_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  mls_pkg::ctrl_type    ctrl,
   output mls_pkg::stat_type    stat,
   input  logic [2:0]           req_action,
   input  logic [2:0]           req_unit_sel,
   input  logic [31:0]          req_now_ms,
   input  logic                 req_reply_ok,
   input  logic signed [31:0]   req_target_value,
   input  logic                 link_ready,
   input  logic [3:0]           active_units,
   input  logic [15:0]          keepalive_period,
   input  logic [15:0]          reprobe_period,
   input  logic [7:0]           drop_threshold,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [3:0]           rsp_send_kind,
   output logic [2:0]           rsp_dest_unit,
   output logic signed [31:0]   rsp_send_arg,
   output logic                 rsp_any_connected,
   output logic                 rsp_last_of_run
);
   import mls_pkg::*;

   logic [MaxUnits-1:0] energized_ff, energized_in;
   logic [MaxUnits-1:0] connected_ff, connected_in;
   logic [7:0]  miss_ff [MaxUnits];
   logic [31:0] lastcmd_ff [MaxUnits];
   logic [31:0] reprobe_ff [MaxUnits];
   logic [2:0]  poll_idx_ff;
   logic [1:0]  poll_var_ff;
   logic [1:0]  pend_kind_ff;
   logic [2:0]  pend_unit_ff;

   logic [2:0]  action_ff;
   logic [2:0]  unit_ff;
   logic [31:0] now_ff;
   logic        ok_ff;
   logic signed [31:0] value_ff;
   logic signed [31:0] vel_ff;
   logic [3:0]  scan_ff;

   logic        valid_ff;
   logic [3:0]  kind_ff;
   logic [2:0]  dest_ff;
   logic signed [31:0] arg_ff;
   logic        anyc_ff;
   logic        last_ff;

   logic [3:0]  limit;
   logic [2:0]  scan_u;
   logic [2:0]  poll_u;
   logic        reprobe_due;
   logic [7:0]  miss_inc;
   logic        anyc;
   logic signed [63:0] vel_wide;

   assign limit  = (active_units > 4'(MaxUnits)) ? 4'(MaxUnits) : active_units;
   assign scan_u = scan_ff[2:0];
   assign poll_u = poll_idx_ff;
   assign reprobe_due = (now_ff - reprobe_ff[poll_u]) >= {16'd0, reprobe_period};
   assign miss_inc    = (miss_ff[pend_unit_ff] == 8'd255) ? 8'd255 : miss_ff[pend_unit_ff] + 8'd1;
   assign vel_wide    = 64'(value_ff) * 64'(WireScale);

   always_comb begin
      anyc = 1'b0;
      for (int i = 0; i < MaxUnits; i++)
         if (4'(i) < limit && connected_ff[i]) anyc = 1'b1;
      anyc = anyc & link_ready;
   end

   always_comb begin
      stat.action           = action_ff;
      stat.link_ready       = link_ready;
      stat.sel_energized    = energized_ff[unit_ff];
      stat.scan_done        = scan_ff >= limit;
      stat.scan_last        = (scan_ff + 4'd1) >= limit;
      stat.scan_hit         = energized_ff[scan_u] &&
                              ((now_ff - lastcmd_ff[scan_u]) >= {16'd0, keepalive_period});
      stat.no_units         = limit == 4'd0;
      stat.poll_emit        = connected_ff[poll_u] || reprobe_due;
      stat.poll_connected   = connected_ff[poll_u];
      stat.outcome_energize = pend_kind_ff == PEND_PROBE && ok_ff && link_ready;
      stat.out_busy         = valid_ff && !rsp_ready;
   end

   always_comb begin
      energized_in = energized_ff;
      connected_in = connected_ff;
      if (ctrl.energize) energized_in[unit_ff] = 1'b1;
      if (ctrl.deenergize) energized_in[scan_u] = 1'b0;
      if (ctrl.outcome && pend_kind_ff != PEND_NONE) begin
         if (ok_ff) connected_in[pend_unit_ff] = 1'b1;
         else if (miss_inc == drop_threshold) connected_in[pend_unit_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energized_ff <= '0;
         connected_ff <= '0;
         for (int i = 0; i < MaxUnits; i++) begin
            miss_ff[i]    <= '0;
            lastcmd_ff[i] <= '0;
            reprobe_ff[i] <= '0;
         end
         poll_idx_ff  <= '0;
         poll_var_ff  <= '0;
         pend_kind_ff <= PEND_NONE;
         pend_unit_ff <= '0;
         scan_ff      <= '0;
         valid_ff     <= 1'b0;
      end else begin
         energized_ff <= energized_in;
         connected_ff <= connected_in;
         if (ctrl.outcome) begin
            if (pend_kind_ff != PEND_NONE)
               miss_ff[pend_unit_ff] <= ok_ff ? 8'd0 : miss_inc;
            pend_kind_ff <= PEND_NONE;
            // A probe answer energizes through the unit register.
         end
         if (ctrl.scan_step && stat.scan_hit) lastcmd_ff[scan_u] <= now_ff;
         if (ctrl.energize || ctrl.touch) lastcmd_ff[unit_ff] <= now_ff;
         if (ctrl.poll) begin
            if (!connected_ff[poll_u]) begin
               if (reprobe_due) begin
                  reprobe_ff[poll_u] <= now_ff;
                  pend_kind_ff <= PEND_PROBE;
                  pend_unit_ff <= poll_u;
               end
            end else begin
               pend_kind_ff <= PEND_READ;
               pend_unit_ff <= poll_u;
            end
            poll_var_ff <= poll_var_ff + 2'd1;
            if (poll_var_ff == 2'd3)
               poll_idx_ff <= (4'(poll_u) + 4'd1 >= limit) ? 3'd0 : poll_u + 3'd1;
         end
         if (ctrl.scan_clr) scan_ff <= '0;
         else if (ctrl.scan_inc) scan_ff <= scan_ff + 4'd1;
         if (ctrl.emit) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         action_ff <= req_action;
         unit_ff   <= req_unit_sel;
         now_ff    <= req_now_ms;
         ok_ff     <= req_reply_ok;
         value_ff  <= req_target_value;
      end
      if (ctrl.outcome) unit_ff <= pend_unit_ff;
      if (vel_wide > 64'sd2147483647) vel_ff <= 32'sd2147483647;
      else if (vel_wide < -64'sd2147483647) vel_ff <= -32'sd2147483647;
      else vel_ff <= vel_wide[31:0];
      if (ctrl.emit) begin
         kind_ff <= (ctrl.kind == CMD_READ_POS) ? CMD_READ_POS + {2'd0, poll_var_ff} : ctrl.kind;
         dest_ff <= ctrl.unit_scan ? scan_u : (ctrl.kind == CMD_PROBE ||
                    ctrl.kind == CMD_READ_POS) ? poll_u : unit_ff;
         arg_ff  <= ctrl.arg_pos ? value_ff : ctrl.arg_vel ? vel_ff : 32'sd0;
         anyc_ff <= anyc;
         last_ff <= ctrl.last;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_send_kind     = kind_ff;
   assign rsp_dest_unit     = dest_ff;
   assign rsp_send_arg      = arg_ff;
   assign rsp_any_connected = anyc_ff;
   assign rsp_last_of_run   = last_ff;
endmodule

### hw/rtl/mls_controller.sv
// Controller of the multidrop link supervisor: sequences one event into result beats.
// Depends on mls_pkg.
module mls_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mls_pkg::stat_type stat,
   output mls_pkg::ctrl_type ctrl
);
   import mls_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_DISPATCH = 4'd1, S_SCAN = 4'd2, S_POLL = 4'd3,
                          S_EN1 = 4'd4, S_EN2 = 4'd5, S_MOTION = 4'd6, S_HALT = 4'd7,
                          S_EST_H = 4'd8, S_EST_D = 4'd9, S_OUTC = 4'd10, S_VELWAIT = 4'd11,
                          S_KA = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;   // estop results emitted this event
   logic       cnt_full;         // estop result limit reached

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      ctrl = '0;
      state_in = state_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               ctrl.scan_clr = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cnt_in = '0;
            case (stat.action)
               ACT_TICK:    state_in = (stat.link_ready && !stat.no_units) ? S_SCAN : S_IDLE;
               ACT_OUTCOME: state_in = S_OUTC;
               ACT_SETPOS, ACT_SETVEL:
                  state_in = !stat.link_ready ? S_IDLE : stat.sel_energized ? S_VELWAIT : S_EN1;
               ACT_HALT:    state_in = stat.link_ready ? S_HALT : S_IDLE;
               ACT_ESTOP:   state_in = stat.scan_done ? S_IDLE : S_EST_H;
               default:     state_in = S_IDLE;
            endcase
         end
         S_SCAN: begin
            if (stat.scan_done) state_in = S_POLL;
            else if (stat.scan_hit) begin
               ctrl.scan_step = 1'b1;
               state_in = S_KA;
            end else ctrl.scan_inc = 1'b1;
         end
         S_KA: if (!stat.out_busy) begin
            ctrl.emit = 1'b1; ctrl.kind = CMD_KEEPALIVE; ctrl.unit_scan = 1'b1;
            ctrl.last = 1'b1; state_in = S_IDLE;
         end
         S_POLL: if (!stat.out_busy) begin
            ctrl.poll = 1'b1;
            if (stat.poll_emit) begin
               ctrl.emit = 1'b1; ctrl.last = 1'b1;
               // A connected poll unit gets a variable read, any other unit a probe.
               ctrl.kind = stat.poll_connected ? CMD_READ_POS : CMD_PROBE;
            end
            state_in = S_IDLE;
         end
         S_OUTC: begin
            ctrl.outcome = 1'b1;
            state_in = stat.outcome_energize ? S_EN1 : S_IDLE;
         end
         S_EN1: if (!stat.out_busy) begin
            ctrl.emit = 1'b1; ctrl.kind = CMD_ENERGIZE; state_in = S_EN2;
         end
         S_EN2: if (!stat.out_busy) begin
            ctrl.emit = 1'b1; ctrl.kind = CMD_EXIT_SAFE; ctrl.energize = 1'b1;
            ctrl.last = stat.action == ACT_OUTCOME;
            state_in = stat.action == ACT_OUTCOME ? S_IDLE : S_MOTION;
         end
         S_VELWAIT: state_in = S_MOTION;
         S_MOTION: if (!stat.out_busy) begin
            ctrl.emit = 1'b1; ctrl.touch = 1'b1; ctrl.last = 1'b1;
            if (stat.action == ACT_SETPOS) begin
               ctrl.kind = CMD_SET_POS; ctrl.arg_pos = 1'b1;
            end else begin
               ctrl.kind = CMD_SET_VEL; ctrl.arg_vel = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_HALT: if (!stat.out_busy) begin
            ctrl.emit = 1'b1; ctrl.touch = 1'b1; ctrl.last = 1'b1; ctrl.kind = CMD_HALT;
            state_in = S_IDLE;
         end
         S_EST_H: if (!stat.out_busy) begin
            if (stat.link_ready && !cnt_full) begin
               ctrl.emit = 1'b1; ctrl.kind = CMD_HALT; ctrl.unit_scan = 1'b1;
               cnt_in = cnt_ff + 5'd1;
            end
            state_in = S_EST_D;
         end
         S_EST_D: if (!stat.out_busy) begin
            ctrl.deenergize = 1'b1;
            ctrl.scan_inc = 1'b1;
            if (stat.link_ready && !cnt_full) begin
               ctrl.emit = 1'b1; ctrl.kind = CMD_DEENERGIZE; ctrl.unit_scan = 1'b1;
               cnt_in = cnt_ff + 5'd1;
               ctrl.last = (cnt_in == 5'(MaxResults)) || stat.scan_last;
            end
            state_in = stat.scan_last ? S_IDLE : S_EST_H;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
   assign cnt_full = cnt_ff >= 5'(MaxResults);
endmodule

### hw/rtl/multidrop_link_supervisor.sv
// Multidrop link supervisor: takes one event at a time, only while the controller is idle,
// and turns it into zero to sixteen command beats. A tick's keepalive scan looks at one
// unit per cycle, and an estop walks the active units with a halt and a deenergize beat
// each while the link is ready. Results leave through a single register, so a stalled
// result channel holds up the event.
// Depends on mls_pkg, mls_controller and mls_datapath.
module multidrop_link_supervisor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [2:0]         req_unit_sel,
   input  logic [31:0]        req_now_ms,
   input  logic               req_reply_ok,
   input  logic signed [31:0] req_target_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_send_kind,
   output logic [2:0]         rsp_dest_unit,
   output logic signed [31:0] rsp_send_arg,
   output logic               rsp_any_connected,
   output logic               rsp_last_of_run,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import mls_pkg::*;

   logic        link_ready_ff;
   logic [3:0]  active_ff;
   logic [15:0] keepalive_ff, reprobe_ff;
   logic [7:0]  drop_ff;
   ctrl_type    ctrl;
   stat_type    stat;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ready_ff <= 1'b0;
         active_ff     <= '0;
         keepalive_ff  <= 16'd400;
         reprobe_ff    <= 16'd2000;
         drop_ff       <= 8'd3;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            ADDR_LINK_READY: link_ready_ff <= pwdata[0];
            ADDR_ACTIVE:     active_ff     <= pwdata[3:0];
            ADDR_KEEPALIVE:  keepalive_ff  <= pwdata[15:0];
            ADDR_REPROBE:    reprobe_ff    <= pwdata[15:0];
            ADDR_DROP:       drop_ff       <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         ADDR_LINK_READY: prdata = {31'd0, link_ready_ff};
         ADDR_ACTIVE:     prdata = {28'd0, active_ff};
         ADDR_KEEPALIVE:  prdata = {16'd0, keepalive_ff};
         ADDR_REPROBE:    prdata = {16'd0, reprobe_ff};
         ADDR_DROP:       prdata = {24'd0, drop_ff};
         default:         prdata = '0;
      endcase
   end

   mls_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .stat, .ctrl
   );

   mls_datapath u_dp (
      .clock, .reset, .ctrl, .stat,
      .req_action, .req_unit_sel, .req_now_ms, .req_reply_ok, .req_target_value,
      .link_ready(link_ready_ff), .active_units(active_ff),
      .keepalive_period(keepalive_ff), .reprobe_period(reprobe_ff),
      .drop_threshold(drop_ff),
      .rsp_valid, .rsp_ready, .rsp_send_kind, .rsp_dest_unit, .rsp_send_arg,
      .rsp_any_connected, .rsp_last_of_run
   );

   a_no_kind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_send_kind != 4'd0) else $error("result with kind zero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
endmodule

### dv/multidrop_link_supervisor_tb.sv
// Self-checking testbench for the multidrop link supervisor: drives events and register
// writes, predicts the command beats and checks each one. Depends on mls_pkg and the RTL.
`timescale 1ns / 100ps

module multidrop_link_supervisor_tb;
   import mls_pkg::*;

   typedef struct packed {
      logic [2:0]  action;
      logic [2:0]  unit_sel;
      logic [31:0] now_ms;
      logic        reply_ok;
      logic [31:0] target_value;
   } event_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [2:0]  unit;
      logic [31:0] arg;
      logic        anyc;
      logic        last;
   } command_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_action = '0;
   logic [2:0] req_unit_sel = '0;
   logic [31:0] req_now_ms = '0;
   logic req_reply_ok = 1'b0;
   logic signed [31:0] req_target_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [3:0] rsp_send_kind;
   logic [2:0] rsp_dest_unit;
   logic signed [31:0] rsp_send_arg;
   logic rsp_any_connected, rsp_last_of_run;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   multidrop_link_supervisor DUT (.*);

   always #4 clock = ~clock;

   // Predictor state.
   logic        link_up;
   logic [3:0]  n_active;
   logic [15:0] ka_period, rp_period;
   logic [7:0]  drop_thr;
   logic        energized [8];
   logic        connected [8];
   logic [7:0]  misses [8];
   logic [31:0] last_cmd [8];
   logic [31:0] last_probe [8];
   logic [2:0]  poll_idx;
   logic [1:0]  poll_var;
   logic [1:0]  pend_kind;
   logic [2:0]  pend_unit;

   event_type   pending_events[$];
   command_type expected_cmds[$];
   command_type run_cmds[$];
   int errors = 0;
   int idle_pct = 0, stall_pct = 0;
   int cycles = 0;
   logic [31:0] clock_ms = 32'd1000;
   logic req_ready_seen = 1'b0;

   task automatic report(string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   function automatic void push_cmd(logic [3:0] kind, logic [2:0] unit, logic [31:0] arg);
      command_type c;
      if (run_cmds.size() >= MaxResults) return;
      c = '{kind: kind, unit: unit, arg: arg, anyc: 1'b0, last: 1'b0};
      run_cmds.push_back(c);
   endfunction

   function automatic void power_unit(logic [2:0] u, logic [31:0] now);
      push_cmd(CMD_ENERGIZE, u, 32'd0);
      push_cmd(CMD_EXIT_SAFE, u, 32'd0);
      energized[u] = 1'b1;
      last_cmd[u] = now;
   endfunction

   function automatic void predict_event(event_type e);
      int n, u;
      logic anyc;
      longint w;
      logic found;
      n = (n_active > MaxUnits) ? MaxUnits : int'(n_active);
      run_cmds.delete();
      found = 1'b0;
      case (e.action)
         ACT_TICK: if (link_up && n != 0) begin
            for (int i = 0; i < n && !found; i++)
               if (energized[i] && (e.now_ms - last_cmd[i]) >= ka_period) begin
                  last_cmd[i] = e.now_ms;
                  push_cmd(CMD_KEEPALIVE, 3'(i), 32'd0);
                  found = 1'b1;
               end
            if (!found) begin
               u = poll_idx;
               if (!connected[u]) begin
                  if ((e.now_ms - last_probe[u]) >= rp_period) begin
                     last_probe[u] = e.now_ms;
                     pend_kind = PEND_PROBE;
                     pend_unit = 3'(u);
                     push_cmd(CMD_PROBE, 3'(u), 32'd0);
                  end
               end else begin
                  pend_kind = PEND_READ;
                  pend_unit = 3'(u);
                  push_cmd(CMD_READ_POS + poll_var, 3'(u), 32'd0);
               end
               if (poll_var == 2'd3) begin
                  u++;
                  if (u >= n) u = 0;
                  poll_idx = 3'(u);
               end
               poll_var++;
            end
         end
         ACT_OUTCOME: begin
            if (pend_kind != PEND_NONE) begin
               if (e.reply_ok) begin
                  misses[pend_unit] = 8'd0;
                  connected[pend_unit] = 1'b1;
               end else begin
                  if (misses[pend_unit] != 8'd255) misses[pend_unit]++;
                  if (misses[pend_unit] == drop_thr) connected[pend_unit] = 1'b0;
               end
               if (pend_kind == PEND_PROBE && e.reply_ok && link_up)
                  power_unit(pend_unit, e.now_ms);
            end
            pend_kind = PEND_NONE;
         end
         ACT_SETPOS, ACT_SETVEL: if (link_up) begin
            if (!energized[e.unit_sel]) power_unit(e.unit_sel, e.now_ms);
            if (e.action == ACT_SETPOS) begin
               push_cmd(CMD_SET_POS, e.unit_sel, e.target_value);
            end else begin
               w = longint'($signed(e.target_value)) * WireScale;
               if (w > 64'sd2147483647) w = 64'sd2147483647;
               if (w < -64'sd2147483647) w = -64'sd2147483647;
               push_cmd(CMD_SET_VEL, e.unit_sel, w[31:0]);
            end
            last_cmd[e.unit_sel] = e.now_ms;
         end
         ACT_HALT: if (link_up) begin
            push_cmd(CMD_HALT, e.unit_sel, 32'd0);
            last_cmd[e.unit_sel] = e.now_ms;
         end
         ACT_ESTOP: for (int i = 0; i < n; i++) begin
            if (link_up) begin
               push_cmd(CMD_HALT, 3'(i), 32'd0);
               push_cmd(CMD_DEENERGIZE, 3'(i), 32'd0);
            end
            energized[i] = 1'b0;
         end
         default: ;
      endcase
      anyc = 1'b0;
      if (link_up)
         for (int i = 0; i < n; i++) if (connected[i]) anyc = 1'b1;
      foreach (run_cmds[i]) begin
         run_cmds[i].anyc = anyc;
         run_cmds[i].last = (i == run_cmds.size() - 1);
         expected_cmds.push_back(run_cmds[i]);
      end
   endfunction

   // Driver: the payload is held until the beat is taken.
   always @(negedge clock) begin
      event_type e;
      if (!reset) begin
         if (!req_valid || req_ready_seen) begin
            if (pending_events.size() != 0 && $urandom_range(99) >= idle_pct) begin
               e = pending_events.pop_front();
               req_action <= e.action;
               req_unit_sel <= e.unit_sel;
               req_now_ms <= e.now_ms;
               req_reply_ok <= e.reply_ok;
               req_target_value <= e.target_value;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Monitor: predicts on accepted input beats and checks result beats.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      req_ready_seen <= 1'b0;
      if (!reset && req_valid && req_ready) begin
         req_ready_seen <= 1'b1;
         predict_event('{req_action, req_unit_sel, req_now_ms, req_reply_ok,
                         req_target_value});
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cmds.size() == 0) begin
            report($sformatf("unexpected beat kind %0d", rsp_send_kind));
         end else begin
            command_type x;
            x = expected_cmds.pop_front();
            if (rsp_send_kind !== x.kind)
               report($sformatf("kind %0d, want %0d", rsp_send_kind, x.kind));
            if (rsp_dest_unit !== x.unit)
               report($sformatf("unit %0d, want %0d", rsp_dest_unit, x.unit));
            if (rsp_send_arg !== x.arg)
               report($sformatf("arg %0d, want %0d", rsp_send_arg, $signed(x.arg)));
            if (rsp_any_connected !== x.anyc)
               report($sformatf("any_connected %0b, want %0b", rsp_any_connected, x.anyc));
            if (rsp_last_of_run !== x.last)
               report($sformatf("last %0b, want %0b", rsp_last_of_run, x.last));
         end
      end
      if (cycles > 400000) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_events.size() != 0 || req_valid || expected_cmds.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      logic [31:0] readback;
      readback = '0;
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         ADDR_LINK_READY: begin
            link_up = value[0];
            readback = {31'd0, value[0]};
         end
         ADDR_ACTIVE: begin
            n_active = value[3:0];
            readback = {28'd0, value[3:0]};
         end
         ADDR_KEEPALIVE: begin
            ka_period = value[15:0];
            readback = {16'd0, value[15:0]};
         end
         ADDR_REPROBE: begin
            rp_period = value[15:0];
            readback = {16'd0, value[15:0]};
         end
         ADDR_DROP: begin
            drop_thr = value[7:0];
            readback = {24'd0, value[7:0]};
         end
         default: ;
      endcase
      @(posedge clock);
      if (prdata !== readback || pready !== 1'b1)
         report($sformatf("register %0d reads %0h, want %0h", index, prdata, readback));
   endtask

   task automatic add_event(logic [2:0] action, logic [2:0] unit, logic ok, logic [31:0] value);
      clock_ms += $urandom_range(300);
      pending_events.push_back('{action, unit, clock_ms, ok, value});
   endtask

   // Mostly well-formed traffic: ticks followed by outcomes, with motion, halt, estop and stray actions mixed in.
   task automatic random_events(int count);
      for (int i = 0; i < count; i++) begin
         int r;
         logic [31:0] v;
         r = $urandom_range(99);
         v = $urandom;
         if ($urandom_range(3) == 0) v = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         if (r < 40) begin
            add_event(ACT_TICK, 3'($urandom), 1'($urandom), v);
            if ($urandom_range(3) != 0)
               add_event(ACT_OUTCOME, 3'($urandom), $urandom_range(3) != 0, v);
         end else if (r < 50) add_event(ACT_OUTCOME, 3'($urandom), 1'($urandom), v);
         else if (r < 68) add_event(ACT_SETPOS, 3'($urandom), 1'($urandom), v);
         else if (r < 84) add_event(ACT_SETVEL, 3'($urandom), 1'($urandom), v);
         else if (r < 93) add_event(ACT_HALT, 3'($urandom), 1'($urandom), v);
         else if (r < 97) add_event(ACT_ESTOP, 3'($urandom), 1'($urandom), v);
         else add_event(3'($urandom_range(7)), 3'($urandom), 1'($urandom), v);
         if ($urandom_range(40) == 0) clock_ms += $urandom;
      end
   endtask

   initial begin
      link_up = 1'b0; n_active = 4'd0; ka_period = 16'd400; rp_period = 16'd2000;
      drop_thr = 8'd3;
      for (int i = 0; i < 8; i++) begin
         energized[i] = 1'b0; connected[i] = 1'b0; misses[i] = 8'd0;
         last_cmd[i] = 32'd0; last_probe[i] = 32'd0;
      end
      poll_idx = 3'd0; poll_var = 2'd0; pend_kind = PEND_NONE; pend_unit = 3'd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Link down: ticks, motion and estop send nothing (no units are active yet).
      add_event(ACT_TICK, 3'd0, 1'b0, 32'd0);
      add_event(ACT_SETPOS, 3'd1, 1'b0, 32'd5);
      add_event(ACT_ESTOP, 3'd0, 1'b0, 32'd0);
      add_event(ACT_OUTCOME, 3'd0, 1'b1, 32'd0);
      wait_drained();
      write_reg(ADDR_LINK_READY, 32'd1);
      add_event(ACT_TICK, 3'd0, 1'b0, 32'd0);
      wait_drained();
      write_reg(ADDR_ACTIVE, 32'd8);
      write_reg(ADDR_REPROBE, 32'd1);
      write_reg(ADDR_KEEPALIVE, 32'd65535);
      write_reg(ADDR_DROP, 32'd0);
      add_event(ACT_TICK, 3'd0, 1'b0, 32'd0);
      add_event(ACT_OUTCOME, 3'd0, 1'b1, 32'd0);
      add_event(ACT_TICK, 3'd0, 1'b0, 32'd0);
      add_event(ACT_TICK, 3'd0, 1'b0, 32'd0);
      add_event(ACT_OUTCOME, 3'd0, 1'b0, 32'd0);
      add_event(ACT_SETPOS, 3'd7, 1'b0, 32'h80000000);
      add_event(ACT_SETVEL, 3'd3, 1'b0, 32'h7fffffff);
      add_event(ACT_SETVEL, 3'd3, 1'b0, 32'h80000000);
      add_event(ACT_SETVEL, 3'd2, 1'b1, 32'hffffffff);
      add_event(ACT_HALT, 3'd5, 1'b0, 32'd0);
      add_event(ACT_ESTOP, 3'd0, 1'b0, 32'd0);
      add_event(3'd6, 3'd0, 1'b0, 32'd0);
      add_event(3'd7, 3'd7, 1'b1, 32'hffffffff);
      pending_events.push_back('{ACT_TICK, 3'd0, 32'hffffffff, 1'b0, 32'd0});
      wait_drained();

      write_reg(ADDR_ACTIVE, 32'd15);
      write_reg(ADDR_KEEPALIVE, 32'd1);
      write_reg(ADDR_REPROBE, 32'd65535);
      write_reg(ADDR_DROP, 32'd255);
      random_events(40);
      wait_drained();

      write_reg(ADDR_ACTIVE, 32'd3);
      write_reg(ADDR_KEEPALIVE, 32'd400);
      write_reg(ADDR_REPROBE, 32'd200);
      write_reg(ADDR_DROP, 32'd1);
      idle_pct = 64;
      random_events(40);
      wait_drained();

      write_reg(ADDR_ACTIVE, 32'd8);
      write_reg(ADDR_DROP, 32'd3);
      idle_pct = 0; stall_pct = 64;
      random_events(40);
      wait_drained();

      write_reg(ADDR_ACTIVE, 32'd0);
      random_events(10);
      wait_drained();
      write_reg(ADDR_ACTIVE, 32'd5);
      write_reg(ADDR_LINK_READY, 32'd0);
      idle_pct = 9; stall_pct = 9;
      random_events(20);
      wait_drained();
      write_reg(ADDR_LINK_READY, 32'd1);
      random_events(45);
      wait_drained();
      idle_pct = 0; stall_pct = 0;
      random_events(45);
      wait_drained();

      if (errors == 0 && expected_cmds.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
